>>> rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/utt_pkg.sv
// shared types, constants and byte encoding functions of the transcoder
`timescale 1ns / 1ps
`default_nettype none

package utt_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [15:0] LeadLo  = 16'hD800;
  localparam logic [15:0] LeadHi  = 16'hDBFF;
  localparam logic [15:0] TrailLo = 16'hDC00;
  localparam logic [15:0] TrailHi = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [20:0] ReplCp   = 21'h00FFFD;

  localparam logic [7:0] ReplB0   = 8'hEF;
  localparam logic [7:0] ReplB1   = 8'hBF;
  localparam logic [7:0] ReplB2   = 8'hBD;
  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;

  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  // one request's worth of output: optional replacement first, then one code point
  typedef struct packed {
    logic        pre;
    logic [20:0] cp;
    logic [2:0]  len;
    logic        last;
  } utt_job_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = ReplB0;
      2'd1:    b = ReplB1;
      default: b = ReplB2;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      LenOne: b = {1'b0, cp[6:0]};
      LenTwo: begin
        case (idx)
          2'd0:    b = Lead2 | {3'b000, cp[10:6]};
          default: b = ContMark | {2'b00, cp[5:0]};
        endcase
      end
      LenThree: begin
        case (idx)
          2'd0:    b = Lead3 | {4'b0000, cp[15:12]};
          2'd1:    b = ContMark | {2'b00, cp[11:6]};
          default: b = ContMark | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = Lead4 | {5'b00000, cp[20:18]};
          2'd1:    b = ContMark | {2'b00, cp[17:12]};
          2'd2:    b = ContMark | {2'b00, cp[11:6]};
          default: b = ContMark | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/utt_front.sv
// front end: surrogate pairing and classification of code units into jobs
`timescale 1ns / 1ps
`default_nettype none

module utt_front
  import utt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        string_end_i,
  output utt_job_t         job_o,
  output logic             job_valid_o
);

  logic       pending_q, pending_d;
  logic [9:0] held_q, held_d;
  logic       is_lead, is_trail;
  utt_job_t   job;
  logic       main_valid;

  assign is_lead  = (code_unit_i >= LeadLo) && (code_unit_i <= LeadHi);
  assign is_trail = (code_unit_i >= TrailLo) && (code_unit_i <= TrailHi);

  always_comb begin
    job        = '0;
    job.last   = string_end_i;
    main_valid = 1'b1;
    pending_d  = 1'b0;
    held_d     = held_q;
    if (pending_q && is_trail) begin
      job.cp  = SuppBase + {1'b0, held_q, code_unit_i[9:0]};
      job.len = LenFour;
    end else begin
      job.pre = pending_q;
      if (is_lead) begin
        if (string_end_i) begin
          job.cp  = ReplCp;
          job.len = LenThree;
        end else begin
          main_valid = 1'b0;
          pending_d  = 1'b1;
          held_d     = code_unit_i[9:0];
        end
      end else if (is_trail) begin
        job.cp  = ReplCp;
        job.len = LenThree;
      end else begin
        job.cp = {5'b00000, code_unit_i};
        if (code_unit_i < 16'h0080) begin
          job.len = LenOne;
        end else if (code_unit_i < 16'h0800) begin
          job.len = LenTwo;
        end else begin
          job.len = LenThree;
        end
      end
      // only the replacement is left: make it the main sequence
      if (!main_valid && job.pre) begin
        job.pre    = 1'b0;
        job.cp     = ReplCp;
        job.len    = LenThree;
        main_valid = 1'b1;
      end
    end
  end

  assign job_o       = job;
  assign job_valid_o = accept_i && main_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (accept_i) begin
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utt_queue.sv
// small job queue between front end and byte serializer
`timescale 1ns / 1ps
`default_nettype none

module utt_queue
  import utt_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire utt_job_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output utt_job_t      data_o,
  output logic          valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utt_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utt_back.sv
// back end: serializes queued jobs into UTF-8 bytes through an output register
`timescale 1ns / 1ps
`default_nettype none

module utt_back
  import utt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire utt_job_t job_i,
  input  wire logic     job_valid_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [7:0]    utf8_byte_o,
  output logic          run_last_o,
  output logic          text_end_o
);

  logic       pre_done_q, pre_done_d;
  logic [1:0] idx_q, idx_d;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_last_q, text_end_q;
  logic       out_free, step, pre_act, run_end;
  logic [7:0] cur_byte;

  assign out_free = !valid_q || out_ready_i;
  assign step     = job_valid_i && out_free;
  assign pre_act  = job_i.pre && !pre_done_q;
  assign run_end  = !pre_act && ({1'b0, idx_q} == (job_i.len - 3'd1));
  assign cur_byte = pre_act ? repl_byte(idx_q) : enc_byte(job_i.cp, job_i.len, idx_q);

  always_comb begin
    pre_done_d = pre_done_q;
    idx_d      = idx_q;
    job_pop_o  = 1'b0;
    if (step) begin
      if (pre_act && (idx_q == 2'd2)) begin
        // replacement prefix done, start the code point itself
        pre_done_d = 1'b1;
        idx_d      = 2'd0;
      end else if (run_end) begin
        pre_done_d = 1'b0;
        idx_d      = 2'd0;
        job_pop_o  = 1'b1;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_done_q <= 1'b0;
      idx_q      <= 2'd0;
      valid_q    <= 1'b0;
    end else begin
      pre_done_q <= pre_done_d;
      idx_q      <= idx_d;
      if (out_free) begin
        valid_q <= job_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q     <= cur_byte;
      run_last_q <= run_end;
      text_end_q <= run_end && job_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign utf8_byte_o = byte_q;
  assign run_last_o  = run_last_q;
  assign text_end_o  = text_end_q;

endmodule

`default_nettype wire

>>> rtl/core/utf16_to_utf8_transcoder_top.sv
// UTF-16 to UTF-8 transcoder: requests pass the job queue, then the output register
// throughput one output byte per cycle while out_ready_i holds; a code unit gives
// 1 to 6 bytes (a held lead surrogate gives none); the one-byte output register sets this
// requests are taken while the job queue has room, even when output stalls
// reset clears the held surrogate flag, the job queue and the output valid
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder_top
  import utt_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        string_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       utf8_byte_o,
  output logic             run_last_o,
  output logic             text_end_o
);

  utt_job_t push_job, head_job;
  logic     push_valid, q_full, head_valid, pop;
  logic     accept;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  utt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .job_o        (push_job),
    .job_valid_o  (push_valid)
  );

  utt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (head_job),
    .valid_o (head_valid)
  );

  utt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .utf8_byte_o (utf8_byte_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/utt_checker.sv
// port-level checker for the transcoder and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] utf8_byte_o,
  input wire logic       run_last_o,
  input wire logic       text_end_o
);

  // a stalled byte stays offered
  `ASSERT_STD(out_valid_held, out_valid_o && !out_ready_i |=> out_valid_o, "output valid dropped")

  `ASSERT_STD(out_byte_stable, out_valid_o && !out_ready_i |=> $stable(utf8_byte_o), "byte moved")

  // end of string only ever closes a run
  `ASSERT_STD(text_end_on_run_last, out_valid_o && text_end_o |-> run_last_o, "text end inside a run")

  // bytes before the last of a run are lead or continuation bytes of a multibyte sequence
  `ASSERT_STD(inner_byte_high, out_valid_o && !run_last_o |-> utf8_byte_o[7], "ascii inside run")

endmodule

bind utf16_to_utf8_transcoder_top utt_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .utf8_byte_o (utf8_byte_o),
  .run_last_o  (run_last_o),
  .text_end_o  (text_end_o)
);

`default_nettype wire

>>> tb/tb_utf16_to_utf8_transcoder_top.sv
// testbench for the utf-16 to utf-8 transcoder with a byte-level scoreboard
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder_top
  import utt_pkg::*;
();

  localparam int unsigned ItemTarget  = 270;
  localparam int unsigned MaxWait     = 13;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } utf8_beat_t;

  class utf8_byte_scoreboard;
    utf8_beat_t  pending_bytes[$];
    utf8_beat_t  item_bytes[$];
    logic [9:0]  held_bits;
    logic        lead_held;
    int unsigned units_seen;
    int unsigned bytes_checked;
    int unsigned pairs_seen;
    int unsigned repl_seen;
    int unsigned errors;

    function new();
      held_bits     = '0;
      lead_held     = 1'b0;
      units_seen    = 0;
      bytes_checked = 0;
      pairs_seen    = 0;
      repl_seen     = 0;
      errors        = 0;
    endfunction

    function void add_byte(logic [7:0] b);
      utf8_beat_t beat;
      beat.data     = b;
      beat.run_last = 1'b0;
      beat.text_end = 1'b0;
      item_bytes = {item_bytes, beat};
    endfunction

    function void add_replacement();
      repl_seen++;
      add_byte(ReplB0);
      add_byte(ReplB1);
      add_byte(ReplB2);
    endfunction

    function void add_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        add_byte({1'b0, cp[6:0]});
      end else if (cp < 21'h800) begin
        add_byte(Lead2 | {3'b000, cp[10:6]});
        add_byte(ContMark | {2'b00, cp[5:0]});
      end else if (cp < 21'h10000) begin
        add_byte(Lead3 | {4'b0000, cp[15:12]});
        add_byte(ContMark | {2'b00, cp[11:6]});
        add_byte(ContMark | {2'b00, cp[5:0]});
      end else begin
        add_byte(Lead4 | {5'b00000, cp[20:18]});
        add_byte(ContMark | {2'b00, cp[17:12]});
        add_byte(ContMark | {2'b00, cp[11:6]});
        add_byte(ContMark | {2'b00, cp[5:0]});
      end
    endfunction

    // works out the bytes one accepted request produces
    function void note_request(logic [15:0] unit, logic last);
      logic is_lead;
      logic is_trail;
      is_lead  = (unit >= LeadLo) && (unit <= LeadHi);
      is_trail = (unit >= TrailLo) && (unit <= TrailHi);
      units_seen++;
      item_bytes.delete();
      if (lead_held && is_trail) begin
        pairs_seen++;
        add_code_point(SuppBase + {1'b0, held_bits, unit[9:0]});
        lead_held = 1'b0;
        held_bits = '0;
      end else begin
        // a held lead with no trail after it is flushed as a replacement first
        if (lead_held) begin
          add_replacement();
          lead_held = 1'b0;
          held_bits = '0;
        end
        if (is_lead) begin
          if (last) begin
            add_replacement();
          end else begin
            held_bits = unit[9:0];
            lead_held = 1'b1;
          end
        end else if (is_trail) begin
          add_replacement();
        end else begin
          add_code_point({5'b00000, unit});
        end
      end
      if (item_bytes.size() > 0) begin
        item_bytes[item_bytes.size() - 1].run_last = 1'b1;
        item_bytes[item_bytes.size() - 1].text_end = last;
      end
      pending_bytes = {pending_bytes, item_bytes};
    endfunction

    function void check_byte(logic [7:0] data, logic run_last, logic text_end);
      utf8_beat_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected byte %02h run_last %b text_end %b",
                   $realtime, data, run_last, text_end);
        return;
      end
      want = pending_bytes.pop_front();
      if (want.data !== data || want.run_last !== run_last || want.text_end !== text_end) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] byte %0d: expected %02h/%b/%b, got %02h/%b/%b", $realtime,
                   bytes_checked, want.data, want.run_last, want.text_end,
                   data, run_last, text_end);
      end
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] code_unit_i;
  logic        string_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  utf8_byte_o;
  logic        run_last_o;
  logic        text_end_o;

  utf8_byte_scoreboard sb;
  int unsigned         items_sent;
  int unsigned         send_burst;
  int unsigned         recv_burst;
  logic                hold_req;
  int unsigned         stuck_cycles;

  utf16_to_utf8_transcoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_unit_i (code_unit_i),
    .string_end_i(string_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .utf8_byte_o (utf8_byte_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // random wait per request, with occasional runs of back-to-back requests
  function automatic int unsigned draw_wait(inout int unsigned run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run = $urandom_range(8, 20);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  // scoreboard taps: requests are noted before results of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(code_unit_i, string_end_i);
      if (out_valid_o && out_ready_i) sb.check_byte(utf8_byte_o, run_last_o, text_end_o);
    end
  end

  task automatic send_unit(logic [15:0] unit, logic last);
    int unsigned gap;
    gap = draw_wait(send_burst);
    if (gap == 0) begin
      @(negedge clk_i);
    end else begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_unit_i  <= unit;
    string_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_char();
    int unsigned pick;
    logic [15:0] unit;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_unit(16'($urandom_range(0, 16'h7F)), $urandom_range(0, 7) == 0);
    end else if (pick < 45) begin
      send_unit(16'($urandom_range(16'h80, 16'h7FF)), $urandom_range(0, 7) == 0);
    end else if (pick < 65) begin
      unit = 16'($urandom_range(16'h800, 16'hF7FF));
      if (unit >= LeadLo) unit = unit + 16'h0800;
      send_unit(unit, $urandom_range(0, 7) == 0);
    end else if (pick < 85) begin
      send_unit(LeadLo + 16'($urandom_range(0, 1023)), 1'b0);
      send_unit(TrailLo + 16'($urandom_range(0, 1023)), $urandom_range(0, 5) == 0);
    end else if (pick < 89) begin
      send_unit(LeadLo + 16'($urandom_range(0, 1023)), $urandom_range(0, 3) == 0);
    end else if (pick < 93) begin
      send_unit(TrailLo + 16'($urandom_range(0, 1023)), $urandom_range(0, 3) == 0);
    end else begin
      send_unit(16'($urandom()), 1'($urandom_range(0, 1)));
    end
  endtask

  // byte receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HoldCycles;
      end else begin
        stall = draw_wait(recv_burst);
      end
      if (stall == 0) begin
        @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    stuck_cycles = 0;
    @(posedge rst_ni);
    while (stuck_cycles < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("timeout: no handshake for %0d cycles, %0d bytes outstanding",
             StuckLimit, sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic hold_done;
    logic pause_done;
    sb           = new();
    items_sent   = 0;
    send_burst   = 0;
    recv_burst   = 0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    code_unit_i  = '0;
    string_end_i = 1'b0;
    out_ready_i  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // boundaries of each encoding length
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFD, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // lowest and highest supplementary code points
    send_unit(LeadLo, 1'b0);
    send_unit(TrailLo, 1'b0);
    send_unit(LeadHi, 1'b0);
    send_unit(TrailHi, 1'b1);
    // lone trail, lead then plain unit, lead then lead then trail
    send_unit(TrailLo, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    // lead at end of string, held lead before the end of string
    send_unit(16'hDA00, 1'b1);
    send_unit(16'hD900, 1'b0);
    send_unit(16'h20AC, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDB00, 1'b1);
    send_unit(TrailHi, 1'b1);
    drain_results();

    while (items_sent < ItemTarget) begin
      if (!hold_done && items_sent >= 100) begin
        // receiver holds off while the sender keeps pushing back to back
        hold_done  = 1'b1;
        hold_req   = 1'b1;
        send_burst = 24;
      end
      if (!pause_done && items_sent >= 190) begin
        pause_done = 1'b1;
        drain_results();
      end
      send_random_char();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d code units, checked %0d utf-8 bytes", sb.units_seen, sb.bytes_checked);
    $display("covered %0d surrogate pairs and %0d replacements, %0d mismatches",
             sb.pairs_seen, sb.repl_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/utt_pkg.sv
rtl/core/utt_front.sv
rtl/core/utt_queue.sv
rtl/core/utt_back.sv
rtl/core/utf16_to_utf8_transcoder_top.sv
rtl/core/utt_checker.sv
tb/tb_utf16_to_utf8_transcoder_top.sv
